>>> hdl/htr_pkg.sv
// Package for the handle table with reference counts.
// Holds the field widths, parameter defaults, codes and the controller/datapath types.
// No dependencies.
package htr_pkg;

   localparam int OP_W = 2;
   localparam int HANDLE_W = 8;
   localparam int PAYLOAD_W = 64;
   localparam int KIND_PORT_W = 3;
   localparam int STATUS_W = 2;
   localparam int REFS_PORT_W = 16;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_DATA_WIDTH = 64;
   localparam int DEF_REF_WIDTH = 16;
   localparam int DEF_KIND_WIDTH = 3;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_GET    = 2'd1,
      OP_CLOSE  = 2'd2,
      OP_OPEN   = 2'd3
   } htr_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BAD  = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_SAT  = 2'd3
   } htr_status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } htr_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } htr_cmd_type;

endpackage

>>> hdl/htr_req_if.sv
// Request channel of the handle table: valid, ready and the request fields.
// Depends on htr_pkg for the field widths.
interface htr_req_if import htr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [HANDLE_W-1:0]    handle_index;
   logic [PAYLOAD_W-1:0]   payload;
   logic [KIND_PORT_W-1:0] kind;

   modport source (output valid, operation, handle_index, payload, kind, input ready);
   modport sink   (input valid, operation, handle_index, payload, kind, output ready);
endinterface

>>> hdl/htr_rsp_if.sv
// Response channel of the handle table: valid, ready and the result fields.
// Depends on htr_pkg for the field widths.
interface htr_rsp_if import htr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [HANDLE_W-1:0]    result_handle;
   logic [PAYLOAD_W-1:0]   result_data;
   logic [KIND_PORT_W-1:0] result_kind;
   logic [REFS_PORT_W-1:0] ref_count;
   logic                   released;

   modport source (output valid, status, result_handle, result_data, result_kind, ref_count,
                   released, input ready);
   modport sink   (input valid, status, result_handle, result_data, result_kind, ref_count,
                   released, output ready);
endinterface

>>> hdl/htr_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module htr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/htr_controller.sv
// Controller of the handle table: the state machine and the response valid flag.
// Depends on htr_pkg; drives the capture and execute commands of htr_datapath.
module htr_controller import htr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output htr_cmd_type cmd
);
   htr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.execute || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_EXEC)
      else $error("captured item did not move to execution");
   a_execute_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("executed item did not present a result");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten before it was taken");
endmodule

>>> hdl/htr_datapath.sv
// Datapath of the handle table: request and result registers, the entry and
// free-stack RAMs and the allocation counters. Depends on htr_pkg and htr_ram.
module htr_datapath import htr_pkg::*; #(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
   parameter int REF_WIDTH   = DEF_REF_WIDTH,
   parameter int KIND_WIDTH  = DEF_KIND_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  htr_cmd_type            cmd,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [HANDLE_W-1:0]    req_handle_index,
   input  logic [PAYLOAD_W-1:0]   req_payload,
   input  logic [KIND_PORT_W-1:0] req_kind,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [HANDLE_W-1:0]    rsp_result_handle,
   output logic [PAYLOAD_W-1:0]   rsp_result_data,
   output logic [KIND_PORT_W-1:0] rsp_result_kind,
   output logic [REFS_PORT_W-1:0] rsp_ref_count,
   output logic                   rsp_released
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ENT_W = 1 + REF_WIDTH + KIND_WIDTH + DATA_WIDTH;

   // Request registers.
   htr_op_type              op_ff, op_in;
   logic [HANDLE_W-1:0]     handle_ff;
   logic [DATA_WIDTH-1:0]   payload_ff, payload_in;
   logic [KIND_WIDTH-1:0]   kind_ff, kind_in;

   // Handles below next_fresh have been handed out at least once; released
   // handles sit on the stack with rel_cnt entries. This stands in for the
   // preloaded free stack, so no clearing pass is needed after reset.
   logic [CNT_W-1:0]        next_fresh_ff, next_fresh_in;
   logic [CNT_W-1:0]        rel_cnt_ff, rel_cnt_in;
   logic [CNT_W-1:0]        rel_dec;

   logic [IDX_W+HANDLE_W-1:0] req_handle_ext, handle_ext;
   logic [IDX_W-1:0]        ent_rd_addr, stk_rd_addr;
   logic [ENT_W-1:0]        ent_rd, ent_wr_data;
   logic [IDX_W-1:0]        stk_rd, ent_wr_addr, stk_wr_addr, stk_wr_data;
   logic                    ent_wr_req, stk_wr_req;

   logic                    ent_live;
   logic [REF_WIDTH-1:0]    ent_refs, refs_dec, refs_inc;
   logic [KIND_WIDTH-1:0]   ent_kind;
   logic [DATA_WIDTH-1:0]   ent_data;
   logic                    in_range, allocated, live, full;
   logic [IDX_W-1:0]        idx, new_idx;

   htr_status_type          status_ff, status_in;
   logic [HANDLE_W-1:0]     res_handle_ff, res_handle_in;
   logic [PAYLOAD_W-1:0]    res_data_ff, res_data_in;
   logic [KIND_PORT_W-1:0]  res_kind_ff, res_kind_in;
   logic [REFS_PORT_W-1:0]  res_refs_ff, res_refs_in;
   logic                    res_released_ff, res_released_in;

   assign op_in          = htr_op_type'(req_operation);
   assign payload_in     = DATA_WIDTH'(req_payload);
   assign kind_in        = KIND_WIDTH'(req_kind);
   assign req_handle_ext = {{IDX_W{1'b0}}, req_handle_index};
   assign ent_rd_addr    = req_handle_ext[IDX_W-1:0];
   assign rel_dec        = rel_cnt_ff - CNT_W'(1);
   assign stk_rd_addr    = rel_dec[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= op_in;
         handle_ff  <= req_handle_index;
         payload_ff <= payload_in;
         kind_ff    <= kind_in;
      end
   end

   htr_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.execute && ent_wr_req),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd)
   );

   htr_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (cmd.execute && stk_wr_req),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd)
   );

   assign ent_live   = ent_rd[ENT_W-1];
   assign ent_refs   = ent_rd[ENT_W-2 -: REF_WIDTH];
   assign ent_kind   = ent_rd[DATA_WIDTH+KIND_WIDTH-1 -: KIND_WIDTH];
   assign ent_data   = ent_rd[DATA_WIDTH-1:0];
   assign refs_dec   = ent_refs - REF_WIDTH'(1);
   assign refs_inc   = ent_refs + REF_WIDTH'(1);

   assign handle_ext = {{IDX_W{1'b0}}, handle_ff};
   assign idx        = handle_ext[IDX_W-1:0];
   assign in_range   = 32'(handle_ff) < 32'(TABLE_DEPTH);
   assign allocated  = CNT_W'(idx) < next_fresh_ff;
   assign live       = in_range && allocated && ent_live;
   assign full       = (rel_cnt_ff == '0) && (next_fresh_ff == CNT_W'(TABLE_DEPTH));
   assign new_idx    = (rel_cnt_ff != '0) ? stk_rd : next_fresh_ff[IDX_W-1:0];

   always_comb begin
      ent_wr_req      = 1'b0;
      ent_wr_addr     = idx;
      ent_wr_data     = ent_rd;
      stk_wr_req      = 1'b0;
      stk_wr_addr     = rel_cnt_ff[IDX_W-1:0];
      stk_wr_data     = idx;
      next_fresh_in   = next_fresh_ff;
      rel_cnt_in      = rel_cnt_ff;
      status_in       = STATUS_OK;
      res_handle_in   = handle_ff;
      res_data_in     = '0;
      res_kind_in     = '0;
      res_refs_in     = '0;
      res_released_in = 1'b0;
      unique case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in     = STATUS_FULL;
               res_handle_in = '0;
            end else begin
               res_handle_in = HANDLE_W'(new_idx);
               res_refs_in   = REFS_PORT_W'(1);
               ent_wr_req    = 1'b1;
               ent_wr_addr   = new_idx;
               ent_wr_data   = {1'b1, REF_WIDTH'(1), kind_ff, payload_ff};
               if (rel_cnt_ff != '0) begin
                  rel_cnt_in = rel_dec;
               end else begin
                  next_fresh_in = next_fresh_ff + CNT_W'(1);
               end
            end
         end
         OP_GET: begin
            if (!live) begin
               status_in = STATUS_BAD;
            end else begin
               res_data_in = PAYLOAD_W'(ent_data);
               res_kind_in = KIND_PORT_W'(ent_kind);
               res_refs_in = REFS_PORT_W'(ent_refs);
            end
         end
         OP_CLOSE: begin
            if (!live) begin
               status_in = STATUS_BAD;
            end else begin
               ent_wr_req  = 1'b1;
               ent_wr_data = {refs_dec != '0, refs_dec, ent_kind, ent_data};
               res_refs_in = REFS_PORT_W'(refs_dec);
               if (refs_dec == '0) begin
                  res_released_in = 1'b1;
                  if (rel_cnt_ff < next_fresh_ff) begin
                     stk_wr_req = 1'b1;
                     rel_cnt_in = rel_cnt_ff + CNT_W'(1);
                  end
               end
            end
         end
         OP_OPEN: begin
            if (!live) begin
               status_in = STATUS_BAD;
            end else if (&ent_refs) begin
               status_in   = STATUS_SAT;
               res_data_in = PAYLOAD_W'(ent_data);
               res_refs_in = REFS_PORT_W'(ent_refs);
            end else begin
               ent_wr_req  = 1'b1;
               ent_wr_data = {1'b1, refs_inc, ent_kind, ent_data};
               res_data_in = PAYLOAD_W'(ent_data);
               res_refs_in = REFS_PORT_W'(refs_inc);
            end
         end
         default: status_in = STATUS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_fresh_ff <= '0;
         rel_cnt_ff    <= '0;
      end else if (cmd.execute) begin
         next_fresh_ff <= next_fresh_in;
         rel_cnt_ff    <= rel_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff       <= status_in;
         res_handle_ff   <= res_handle_in;
         res_data_ff     <= res_data_in;
         res_kind_ff     <= res_kind_in;
         res_refs_ff     <= res_refs_in;
         res_released_ff <= res_released_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_result_handle = res_handle_ff;
   assign rsp_result_data   = res_data_ff;
   assign rsp_result_kind   = res_kind_ff;
   assign rsp_ref_count     = res_refs_ff;
   assign rsp_released      = res_released_ff;

   a_counts_consistent: assert property (@(posedge clock) disable iff (reset)
      rel_cnt_ff <= next_fresh_ff && next_fresh_ff <= CNT_W'(TABLE_DEPTH))
      else $error("free handle counts out of range");
   a_full_insert_no_change: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && op_ff == OP_INSERT && full |=>
         $stable(next_fresh_ff) && $stable(rel_cnt_ff))
      else $error("insert into a full table changed the free counts");
endmodule

>>> hdl/handle_table_refcount.sv
// Handle table with reference counts: insert, get, open and close on up to
// TABLE_DEPTH entries. Uses htr_pkg, htr_req_if, htr_rsp_if, htr_controller,
// htr_datapath and htr_ram.
//
// Each item first reads the entry RAM and the free-stack RAM (both have a
// registered read port), then updates the entry, pushes or pops a free handle
// and loads the result register. The next item is accepted in the cycle after
// that, while the previous result may still wait in the output register; a result
// not taken stalls the block after one further item. After reset handles are
// handed out in ascending order from a fill counter, so the block is ready at
// once with no clearing pass; released handles are reused last released first.
// Handles at or above TABLE_DEPTH or not in use are refused.
module handle_table_refcount import htr_pkg::*; #(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
   parameter int REF_WIDTH   = DEF_REF_WIDTH,
   parameter int KIND_WIDTH  = DEF_KIND_WIDTH
) (
   input logic       clock,
   input logic       reset,
   htr_req_if.sink   req_chan,
   htr_rsp_if.source rsp_chan
);
   htr_cmd_type cmd;

   htr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   htr_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH),
      .REF_WIDTH   (REF_WIDTH),
      .KIND_WIDTH  (KIND_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_chan.operation),
      .req_handle_index  (req_chan.handle_index),
      .req_payload       (req_chan.payload),
      .req_kind          (req_chan.kind),
      .rsp_status        (rsp_chan.status),
      .rsp_result_handle (rsp_chan.result_handle),
      .rsp_result_data   (rsp_chan.result_data),
      .rsp_result_kind   (rsp_chan.result_kind),
      .rsp_ref_count     (rsp_chan.ref_count),
      .rsp_released      (rsp_chan.released)
   );
endmodule
